// ----- hw/rtl/multirotor_motor_mixer_defines.svh -----
// Assertion macros for the multirotor motor mixer.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef MULTIROTOR_MOTOR_MIXER_DEFINES_SVH
`define MULTIROTOR_MOTOR_MIXER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define MMIX_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("motor mixer assertion failed");

// Next-cycle implication, disabled while reset is held.
`define MMIX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("motor mixer assertion failed");

`endif

// ----- hw/rtl/mmix_pkg.sv -----
// Types, constants and helper functions for the multirotor motor mixer.
// Has no dependencies; used by the interfaces and the top level.
`timescale 1ns / 1ps

package mmix_pkg;

  localparam int unsigned Q_FRAC     = 12;
  localparam int unsigned LVL_W      = 13;
  localparam int unsigned CORR_W     = 16;
  localparam int unsigned FAC_W      = 3 * CORR_W;
  localparam int unsigned PROD_W     = 2 * CORR_W;
  localparam int unsigned SUM_W      = PROD_W + 2;
  localparam int unsigned QUO_W      = SUM_W - Q_FRAC;
  localparam int unsigned MAX_MOTORS = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = FAC_W;

  typedef logic [LVL_W-1:0]         level_t;
  typedef logic signed [CORR_W-1:0] q12_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [FAC_W-1:0]         factors_t;

  localparam level_t ONE_Q12 = level_t'(1 << Q_FRAC);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FLOOR   = 3'd0,
    REG_CEILING = 3'd1,
    REG_IDLE    = 3'd2,
    REG_FACTOR0 = 3'd3,
    REG_FACTOR1 = 3'd4,
    REG_FACTOR2 = 3'd5,
    REG_FACTOR3 = 3'd6
  } cfg_reg_t;

  function automatic level_t unit_clamp(input q12_t v);
    level_t res;
    if (v < 0) begin
      res = '0;
    end else if (v > $signed(CORR_W'(ONE_Q12))) begin
      res = ONE_Q12;
    end else begin
      res = v[LVL_W-1:0];
    end
    return res;
  endfunction

  function automatic level_t min_one(input level_t v);
    return (v > ONE_Q12) ? ONE_Q12 : v;
  endfunction

endpackage

// ----- hw/rtl/mmix_ifs.sv -----
// Valid/ready channel interfaces for the mixer's input and result words.
// Depends on mmix_pkg for the field types.
`timescale 1ns / 1ps

interface mmix_in_if;
  logic               valid;
  logic               ready;
  mmix_pkg::q12_t     throttle_cmd;
  mmix_pkg::q12_t     roll_corr;
  mmix_pkg::q12_t     pitch_corr;
  mmix_pkg::q12_t     yaw_corr;
  logic               is_armed;

  modport source (output valid, throttle_cmd, roll_corr, pitch_corr, yaw_corr, is_armed,
                  input ready);
  modport sink (input valid, throttle_cmd, roll_corr, pitch_corr, yaw_corr, is_armed,
                output ready);
endinterface

interface mmix_out_if;
  logic               valid;
  logic               ready;
  mmix_pkg::level_t   motor0_out;
  mmix_pkg::level_t   motor1_out;
  mmix_pkg::level_t   motor2_out;
  mmix_pkg::level_t   motor3_out;

  modport source (output valid, motor0_out, motor1_out, motor2_out, motor3_out,
                  input ready);
  modport sink (input valid, motor0_out, motor1_out, motor2_out, motor3_out,
                output ready);
endinterface

// ----- hw/rtl/multirotor_motor_mixer.sv -----
// Top level of the multirotor motor mixer: config registers and a three-stage datapath.
// Depends on mmix_pkg, mmix_ifs.sv and multirotor_motor_mixer_defines.svh.
//
//   channel   direction  handshake           contents
//   in_if     sink       valid/ready         throttle, roll, pitch, yaw, armed flag
//   out_if    source     valid/ready         four motor drive levels
//   cfg_*     input      cfg_we only         register index and write data
//
// One word is accepted per cycle while out_if keeps up; a word taken in passes through the input
// register, the multiplier stage and the sum/clamp stage before it is on out_if.
// Synchronous active-low reset empties the pipeline and restores the register defaults.
// Each stage advances when the stage after it is empty or advancing, so a stall at out_if
// backs up one stage at a time and in_if.ready falls only when all three stages are full.
`timescale 1ns / 1ps
`include "multirotor_motor_mixer_defines.svh"

module multirotor_motor_mixer #(
  parameter int MOTORS = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  mmix_in_if.sink                           in_if,
  mmix_out_if.source                        out_if,
  input  logic                              cfg_we,
  input  logic [mmix_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mmix_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int unsigned LW = mmix_pkg::LVL_W;
  localparam int unsigned CW = mmix_pkg::CORR_W;

  // Configuration registers.
  mmix_pkg::level_t   floor_r;
  mmix_pkg::level_t   ceil_r;
  mmix_pkg::level_t   idle_r;
  mmix_pkg::factors_t fac_r [MOTORS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= '0;
      ceil_r  <= mmix_pkg::ONE_Q12;
      idle_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mmix_pkg::REG_FLOOR:   floor_r <= cfg_wdata[LW-1:0];
        mmix_pkg::REG_CEILING: ceil_r  <= cfg_wdata[LW-1:0];
        mmix_pkg::REG_IDLE:    idle_r  <= cfg_wdata[LW-1:0];
        default: ;
      endcase
    end
  end

  for (genvar m = 0; m < MOTORS; m++) begin : g_fac
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        fac_r[m] <= '0;
      end else if (cfg_we &&
                   cfg_index == mmix_pkg::CFG_IDX_W'(mmix_pkg::REG_FACTOR0) +
                                mmix_pkg::CFG_IDX_W'(m)) begin
        fac_r[m] <= cfg_wdata[mmix_pkg::FAC_W-1:0];
      end
    end
  end

  // Effective limits, recomputed every cycle from the registers.
  mmix_pkg::level_t eff_lo_r, eff_hi_r, eff_idle_r;
  mmix_pkg::level_t eff_lo_nxt, eff_hi_nxt, eff_idle_nxt;

  always_comb begin
    if (floor_r > ceil_r) begin
      eff_lo_nxt = mmix_pkg::min_one(ceil_r);
      eff_hi_nxt = mmix_pkg::min_one(floor_r);
    end else begin
      eff_lo_nxt = mmix_pkg::min_one(floor_r);
      eff_hi_nxt = mmix_pkg::min_one(ceil_r);
    end
    eff_idle_nxt = mmix_pkg::min_one(idle_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_lo_r   <= '0;
      eff_hi_r   <= mmix_pkg::ONE_Q12;
      eff_idle_r <= '0;
    end else begin
      eff_lo_r   <= eff_lo_nxt;
      eff_hi_r   <= eff_hi_nxt;
      eff_idle_r <= eff_idle_nxt;
    end
  end

  // Stage handshake.
  logic s1_v_r, s2_v_r, s3_v_r;
  logic s1_rdy, s2_rdy, s3_rdy;

  assign s3_rdy      = !s3_v_r || out_if.ready;
  assign s2_rdy      = !s2_v_r || s3_rdy;
  assign s1_rdy      = !s1_v_r || s2_rdy;
  assign in_if.ready = s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_r <= in_if.valid;
      end
      if (s2_rdy) begin
        s2_v_r <= s1_v_r;
      end
      if (s3_rdy) begin
        s3_v_r <= s2_v_r;
      end
    end
  end

  // Stage 1: input register.
  mmix_pkg::q12_t s1_thr_r, s1_roll_r, s1_pitch_r, s1_yaw_r;
  logic           s1_arm_r;

  always_ff @(posedge clk) begin
    if (s1_rdy && in_if.valid) begin
      s1_thr_r   <= in_if.throttle_cmd;
      s1_roll_r  <= in_if.roll_corr;
      s1_pitch_r <= in_if.pitch_corr;
      s1_yaw_r   <= in_if.yaw_corr;
      s1_arm_r   <= in_if.is_armed;
    end
  end

  // Stage 2: base throttle and the weighted corrections.
  mmix_pkg::level_t s2_base_nxt;
  mmix_pkg::level_t s2_base_r;
  logic             s2_arm_r;
  mmix_pkg::prod_t  s2_roll_r  [MOTORS];
  mmix_pkg::prod_t  s2_pitch_r [MOTORS];
  mmix_pkg::prod_t  s2_yaw_r   [MOTORS];

  always_comb begin
    s2_base_nxt = mmix_pkg::unit_clamp(s1_thr_r);
    if (s2_base_nxt < eff_idle_r) begin
      s2_base_nxt = eff_idle_r;
    end
    if (s2_base_nxt < eff_lo_r) begin
      s2_base_nxt = eff_lo_r;
    end else if (s2_base_nxt > eff_hi_r) begin
      s2_base_nxt = eff_hi_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy && s1_v_r) begin
      s2_base_r <= s2_base_nxt;
      s2_arm_r  <= s1_arm_r;
    end
  end

  for (genvar m = 0; m < MOTORS; m++) begin : g_mul
    always_ff @(posedge clk) begin
      if (s2_rdy && s1_v_r) begin
        s2_roll_r[m]  <= s1_roll_r  * $signed(fac_r[m][CW-1:0]);
        s2_pitch_r[m] <= s1_pitch_r * $signed(fac_r[m][2*CW-1:CW]);
        s2_yaw_r[m]   <= s1_yaw_r   * $signed(fac_r[m][3*CW-1:2*CW]);
      end
    end
  end

  // Stage 3: exact sum, floor shift and saturation (or the low limit when disarmed) into the output register.
  mmix_pkg::level_t s3_mot_r [MOTORS];

  for (genvar m = 0; m < MOTORS; m++) begin : g_sum
    logic signed [mmix_pkg::SUM_W-1:0] sum;
    logic signed [mmix_pkg::QUO_W-1:0] quo;
    logic signed [mmix_pkg::QUO_W-1:0] lo_q, hi_q;
    mmix_pkg::level_t                  mot_nxt;

    always_comb begin
      sum = $signed({{(mmix_pkg::SUM_W - LW - mmix_pkg::Q_FRAC){1'b0}},
                     s2_base_r, {mmix_pkg::Q_FRAC{1'b0}}})
          + mmix_pkg::SUM_W'(s2_roll_r[m])
          + mmix_pkg::SUM_W'(s2_pitch_r[m])
          + mmix_pkg::SUM_W'(s2_yaw_r[m]);
      quo  = sum[mmix_pkg::SUM_W-1:mmix_pkg::Q_FRAC];
      lo_q = $signed({{(mmix_pkg::QUO_W - LW){1'b0}}, eff_lo_r});
      hi_q = $signed({{(mmix_pkg::QUO_W - LW){1'b0}}, eff_hi_r});
      if (!s2_arm_r) begin
        mot_nxt = eff_lo_r;
      end else if (quo < lo_q) begin
        mot_nxt = eff_lo_r;
      end else if (quo > hi_q) begin
        mot_nxt = eff_hi_r;
      end else begin
        mot_nxt = quo[LW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (s3_rdy && s2_v_r) begin
        s3_mot_r[m] <= mot_nxt;
      end
    end
  end

  mmix_pkg::level_t mot_out [mmix_pkg::MAX_MOTORS];

  for (genvar k = 0; k < mmix_pkg::MAX_MOTORS; k++) begin : g_out
    if (k < MOTORS) begin : g_on
      assign mot_out[k] = s3_mot_r[k];
    end else begin : g_off
      assign mot_out[k] = '0;
    end
  end

  assign out_if.valid      = s3_v_r;
  assign out_if.motor0_out = mot_out[0];
  assign out_if.motor1_out = mot_out[1];
  assign out_if.motor2_out = mot_out[2];
  assign out_if.motor3_out = mot_out[3];

  `MMIX_ASSERT_IMPL(a_out_in_range, out_if.valid, (s3_mot_r[0] >= eff_lo_r) && (s3_mot_r[0] <= eff_hi_r))
  `MMIX_ASSERT_IMPL(a_stall_only_when_full, !in_if.ready, s1_v_r && s2_v_r && s3_v_r)
  `MMIX_ASSERT_NEXT(a_stage2_moves, s2_v_r && s3_rdy, s3_v_r)

endmodule

// ----- tb/multirotor_motor_mixer_tb.sv -----
// Self-checking testbench for multirotor_motor_mixer: directed and random control words,
// predicted motor levels checked in order, register setups written while the mixer is idle.
// Depends on mmix_pkg, mmix_ifs.sv and the mixer RTL.
`timescale 1ns / 1ps

module multirotor_motor_mixer_tb;

  typedef logic [3:0][mmix_pkg::LVL_W-1:0] drive_set_t;

  localparam longint UNITY = 4096;
  localparam mmix_pkg::q12_t Q_MIN = mmix_pkg::q12_t'(16'h8000);
  localparam mmix_pkg::q12_t Q_MAX = mmix_pkg::q12_t'(16'h7FFF);
  localparam logic [mmix_pkg::CFG_IDX_W-1:0] UNUSED_REG = 3'd7;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [mmix_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mmix_pkg::CFG_DATA_W-1:0] cfg_wdata;

  mmix_in_if in_ch ();
  mmix_out_if out_ch ();

  multirotor_motor_mixer uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_ch.sink),
    .out_if(out_ch.source),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  logic [mmix_pkg::LVL_W-1:0] cfg_floor;
  logic [mmix_pkg::LVL_W-1:0] cfg_ceiling;
  logic [mmix_pkg::LVL_W-1:0] cfg_idle;
  logic [mmix_pkg::FAC_W-1:0] cfg_factors [4];

  drive_set_t pending_drive [$];
  int words_sent;
  int words_checked;
  int mismatches;
  int reg_writes;
  bit send_pacing;
  bit recv_pacing;
  bit hold_req;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic drive_set_t mix_motors(input mmix_pkg::q12_t thr,
                                            input mmix_pkg::q12_t roll,
                                            input mmix_pkg::q12_t pitch,
                                            input mmix_pkg::q12_t yaw,
                                            input logic armed);
    drive_set_t res;
    longint f, c, t, lo, hi, idle, base, sum, lvl;
    logic [mmix_pkg::FAC_W-1:0] fac;
    f = cfg_floor;
    c = cfg_ceiling;
    if (f > c) begin
      t = f;
      f = c;
      c = t;
    end
    lo = (f > UNITY) ? UNITY : f;
    hi = (c > UNITY) ? UNITY : c;
    idle = (cfg_idle > UNITY) ? UNITY : longint'(cfg_idle);
    base = thr;
    if (base < 0) begin
      base = 0;
    end else if (base > UNITY) begin
      base = UNITY;
    end
    if (base < idle) base = idle;
    if (base < lo) begin
      base = lo;
    end else if (base > hi) begin
      base = hi;
    end
    for (int m = 0; m < 4; m++) begin
      if (!armed) begin
        lvl = lo;
      end else begin
        fac = cfg_factors[m];
        sum = base * UNITY
            + longint'(roll) * longint'($signed(fac[15:0]))
            + longint'(pitch) * longint'($signed(fac[31:16]))
            + longint'(yaw) * longint'($signed(fac[47:32]));
        lvl = sum >>> mmix_pkg::Q_FRAC;
        if (lvl < lo) begin
          lvl = lo;
        end else if (lvl > hi) begin
          lvl = hi;
        end
      end
      res[m] = lvl[mmix_pkg::LVL_W-1:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    drive_set_t got, want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.motor3_out, out_ch.motor2_out, out_ch.motor1_out, out_ch.motor0_out};
        if (pending_drive.size() == 0) begin
          $display("%0t unexpected motor word: expected none, got %h", $time, got);
          mismatches++;
        end else begin
          want = pending_drive.pop_front();
          for (int m = 0; m < 4; m++) begin
            if (got[m] !== want[m]) begin
              $display("%0t motor%0d mismatch: expected %0d, got %0d",
                       $time, m, want[m], got[m]);
              mismatches++;
            end
          end
          words_checked++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pending_drive.push_back(mix_motors(in_ch.throttle_cmd, in_ch.roll_corr,
                                           in_ch.pitch_corr, in_ch.yaw_corr,
                                           in_ch.is_armed));
      end
    end
  end

  initial begin
    int gap;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      gap = recv_pacing ? $urandom_range(0, 15) : 0;
      if (gap != 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("%0t timeout with %0d motor words outstanding", $time, pending_drive.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_word(input mmix_pkg::q12_t thr, input mmix_pkg::q12_t roll,
                           input mmix_pkg::q12_t pitch, input mmix_pkg::q12_t yaw,
                           input logic armed);
    int gap;
    gap = send_pacing ? $urandom_range(0, 15) : 0;
    repeat (gap) @(negedge clk);
    in_ch.throttle_cmd = thr;
    in_ch.roll_corr = roll;
    in_ch.pitch_corr = pitch;
    in_ch.yaw_corr = yaw;
    in_ch.is_armed = armed;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid = 1'b0;
    words_sent++;
  endtask

  task automatic write_reg(input logic [mmix_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mmix_pkg::CFG_DATA_W-1:0] data);
    while (pending_drive.size() != 0) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      mmix_pkg::REG_FLOOR: cfg_floor = data[mmix_pkg::LVL_W-1:0];
      mmix_pkg::REG_CEILING: cfg_ceiling = data[mmix_pkg::LVL_W-1:0];
      mmix_pkg::REG_IDLE: cfg_idle = data[mmix_pkg::LVL_W-1:0];
      mmix_pkg::REG_FACTOR0, mmix_pkg::REG_FACTOR1, mmix_pkg::REG_FACTOR2,
      mmix_pkg::REG_FACTOR3: cfg_factors[2'(idx - mmix_pkg::REG_FACTOR0)] = data;
      default: ;
    endcase
    reg_writes++;
  endtask

  function automatic logic [mmix_pkg::LVL_W-1:0] draw_level();
    if ($urandom_range(0, 3) == 0) return mmix_pkg::LVL_W'($urandom_range(0, 8191));
    return mmix_pkg::LVL_W'($urandom_range(0, 4096));
  endfunction

  function automatic mmix_pkg::q12_t draw_factor();
    int mag;
    if ($urandom_range(0, 1) == 0) return mmix_pkg::q12_t'($urandom);
    mag = $urandom_range(0, 4096);
    return mmix_pkg::q12_t'($urandom_range(0, 1) ? mag : -mag);
  endfunction

  function automatic mmix_pkg::q12_t draw_corr();
    if ($urandom_range(0, 3) == 0) return mmix_pkg::q12_t'($urandom);
    return mmix_pkg::q12_t'(int'($urandom_range(0, 6000)) - 3000);
  endfunction

  task automatic send_random_word();
    mmix_pkg::q12_t thr;
    if ($urandom_range(0, 3) == 0) begin
      thr = mmix_pkg::q12_t'($urandom);
    end else begin
      thr = mmix_pkg::q12_t'(int'($urandom_range(0, 4400)) - 150);
    end
    send_word(thr, draw_corr(), draw_corr(), draw_corr(), $urandom_range(0, 9) != 0);
  endtask

  task automatic test_reset_levels();
    send_word(Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1'b1);
    send_word(Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1'b1);
    send_word(16'sd4096, 16'sd0, 16'sd0, 16'sd0, 1'b1);
    send_word(16'sd4097, 16'sd0, 16'sd0, 16'sd0, 1'b1);
    send_word(-16'sd1, 16'sd0, 16'sd0, 16'sd0, 1'b1);
    send_word(16'sd2048, 16'sd1234, -16'sd1234, 16'sd5, 1'b1);
    send_word(Q_MAX, 16'sd0, 16'sd0, 16'sd0, 1'b0);
  endtask

  task automatic test_limit_registers();
    write_reg(mmix_pkg::REG_FACTOR0, {16'h7FFF, 16'h8000, 16'h7FFF});
    write_reg(mmix_pkg::REG_FACTOR1, {16'h8000, 16'h8000, 16'h8000});
    write_reg(mmix_pkg::REG_FACTOR2, {16'h7FFF, 16'h7FFF, 16'h7FFF});
    write_reg(mmix_pkg::REG_FACTOR3, {16'hF000, 16'h1000, 16'h1000});
    // Floor above ceiling: the mixer must use them swapped.
    write_reg(mmix_pkg::REG_FLOOR, 48'd3000);
    write_reg(mmix_pkg::REG_CEILING, 48'd1000);
    write_reg(mmix_pkg::REG_IDLE, 48'd500);
    send_word(16'sd2000, Q_MAX, Q_MAX, Q_MAX, 1'b1);
    send_word(16'sd2000, Q_MIN, Q_MIN, Q_MIN, 1'b1);
    send_word(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    // Levels above full scale, with junk in the unused data bits.
    write_reg(mmix_pkg::REG_FLOOR, 48'hFFFF_FFFF_FFFF);
    write_reg(mmix_pkg::REG_CEILING, 48'd5000);
    write_reg(mmix_pkg::REG_IDLE, 48'd8191);
    send_word(16'sd0, 16'sd100, -16'sd100, 16'sd7, 1'b1);
    send_word(Q_MAX, Q_MIN, 16'sd0, 16'sd0, 1'b0);
    write_reg(UNUSED_REG, 48'hFFFF_FFFF_FFFF);
    write_reg(mmix_pkg::REG_FLOOR, 48'd0);
    write_reg(mmix_pkg::REG_CEILING, 48'd4096);
    write_reg(mmix_pkg::REG_IDLE, 48'd4096);
    send_word(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1);
    send_word(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1);
    send_word(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1);
    write_reg(mmix_pkg::REG_CEILING, 48'd8191);
    write_reg(mmix_pkg::REG_IDLE, 48'd0);
    send_word(16'sd4095, -16'sd1, -16'sd1, -16'sd1, 1'b1);
    send_word(16'sd1, 16'sd3, -16'sd3, 16'sd1, 1'b1);
  endtask

  task automatic test_random_mix();
    logic [mmix_pkg::LVL_W-1:0] lvl_f, lvl_c, lvl_i;
    logic [mmix_pkg::CFG_DATA_W-1:0] wdata;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: begin
          lvl_f = 13'd0;
          lvl_c = 13'd4096;
          lvl_i = 13'd0;
        end
        1: begin
          lvl_f = 13'd4096;
          lvl_c = 13'd4096;
          lvl_i = 13'd4096;
        end
        2: begin
          lvl_f = mmix_pkg::LVL_W'($urandom_range(2048, 4096));
          lvl_c = mmix_pkg::LVL_W'($urandom_range(0, 2047));
          lvl_i = draw_level();
        end
        3: begin
          lvl_f = 13'd8191;
          lvl_c = 13'd0;
          lvl_i = 13'd8191;
        end
        default: begin
          lvl_f = draw_level();
          lvl_c = draw_level();
          lvl_i = draw_level();
        end
      endcase
      wdata = mmix_pkg::CFG_DATA_W'({$urandom, $urandom});
      wdata[mmix_pkg::LVL_W-1:0] = lvl_f;
      write_reg(mmix_pkg::REG_FLOOR, wdata);
      wdata = mmix_pkg::CFG_DATA_W'({$urandom, $urandom});
      wdata[mmix_pkg::LVL_W-1:0] = lvl_c;
      write_reg(mmix_pkg::REG_CEILING, wdata);
      wdata = mmix_pkg::CFG_DATA_W'({$urandom, $urandom});
      wdata[mmix_pkg::LVL_W-1:0] = lvl_i;
      write_reg(mmix_pkg::REG_IDLE, wdata);
      for (int m = 0; m < 4; m++) begin
        write_reg(mmix_pkg::CFG_IDX_W'(int'(mmix_pkg::REG_FACTOR0) + m),
                  {draw_factor(), draw_factor(), draw_factor()});
      end
      for (int n = 0; n < 50; n++) begin
        if (n % 10 == 0) begin
          send_pacing = $urandom_range(0, 1);
          recv_pacing = $urandom_range(0, 1);
        end
        send_random_word();
      end
    end
  endtask

  task automatic test_backpressure();
    send_pacing = 1'b0;
    recv_pacing = 1'b0;
    hold_req = 1'b1;
    for (int n = 0; n < 30; n++) begin
      send_random_word();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.throttle_cmd = '0;
    in_ch.roll_corr = '0;
    in_ch.pitch_corr = '0;
    in_ch.yaw_corr = '0;
    in_ch.is_armed = 1'b0;
    cfg_floor = '0;
    cfg_ceiling = 13'd4096;
    cfg_idle = '0;
    for (int m = 0; m < 4; m++) cfg_factors[m] = '0;
    send_pacing = 1'b1;
    recv_pacing = 1'b1;
    hold_req = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    test_reset_levels();
    test_limit_registers();
    test_random_mix();
    test_backpressure();

    while (pending_drive.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    $display("Sent %0d control words and checked %0d motor words over %0d register writes,",
             words_sent, words_checked, reg_writes);
    $display("covering swapped and over-range limits, disarmed words and a %0d-cycle stall.",
             HOLD_CYCLES);
    if (mismatches == 0 && words_checked == words_sent) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
